[sv/rsa_pkg.sv]
// Shared constants, types and a modular addition helper for the RSA exponentiation block.
package rsa_pkg;

    localparam int MOD_BITS = 32;
    localparam int MOD_W    = MOD_BITS;
    localparam int DATA_W   = 32;
    localparam int EXP_W    = 32;
    localparam int CNT_W    = $clog2(EXP_W + 1);
    localparam int CHAIN_W  = (MOD_BITS > DATA_W) ? MOD_BITS : DATA_W;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS     = 2'd0,
        REG_PUBLIC_EXP  = 2'd1,
        REG_PRIVATE_EXP = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_FINISH = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic             valid;
        logic [MOD_W-1:0] acc;
    } link_t;

    // (a + b) mod m for a, b below m
    function automatic logic [MOD_W-1:0] add_mod(
        input logic [MOD_W-1:0] a,
        input logic [MOD_W-1:0] b,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W-1:0] room;
        room = m - b;
        if (a >= room)
            return a - room;
        return a + b;
    endfunction

endpackage

[sv/rsa_if.sv]
// Valid/ready channel interfaces for requests and results.
interface rsa_req_if;
    import rsa_pkg::*;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DATA_W-1:0] operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

interface rsa_rsp_if;
    import rsa_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              error;

    modport source (output valid, output result_value, output error, input ready);
    modport sink   (input valid, input result_value, input error, output ready);
endinterface

[sv/rsa_cell.sv]
// One step of the shift-and-add modular multiplier: double, then add on a set multiplier bit.
module rsa_cell
    import rsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  link_t            link_in,
    input  logic [MOD_W-1:0] a,
    input  logic [MOD_W-1:0] m,
    input  logic             mul_bit,
    output link_t            link_out
);

    logic [MOD_W-1:0] dbl;
    logic [MOD_W-1:0] acc_next;
    logic             valid_reg;
    logic [MOD_W-1:0] acc_reg;

    assign dbl      = add_mod(link_in.acc, link_in.acc, m);
    assign acc_next = mul_bit ? add_mod(dbl, a, m) : dbl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= link_in.valid;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign link_out.valid = valid_reg;
    assign link_out.acc   = acc_reg;

endmodule

[sv/rsa_chain.sv]
// Row of multiplier cells; one modular product walks the row, one multiplier bit per cell.
module rsa_chain
    import rsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               launch,
    input  logic [MOD_W-1:0]   a,
    input  logic [CHAIN_W-1:0] b,
    input  logic [MOD_W-1:0]   m,
    output link_t              done
);

    link_t links [CHAIN_W+1];
    logic [CHAIN_W-1:0] valid_vec;

    assign links[0].valid = launch;
    assign links[0].acc   = '0;

    for (genvar k = 0; k < CHAIN_W; k++)
    begin : g_cell
        rsa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[k]),
            .a        (a),
            .m        (m),
            .mul_bit  (b[CHAIN_W-1-k]),
            .link_out (links[k+1])
        );
        assign valid_vec[k] = links[k+1].valid;
    end

    assign done = links[CHAIN_W];

    a_single_product: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_vec))
        else $error("more than one product in flight");

    a_no_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        launch |-> valid_vec == '0)
        else $error("launch while a product is in flight");

endmodule

[sv/rsa_encrypt_decrypt_core.sv]
// Top level: configuration registers, square-and-multiply sequencer and result register.
//
// Usage:
//   Write modulus (index 0), public exponent (1) and private exponent (2) on the
//   cfg_we / cfg_index / cfg_wdata port while no request is in progress.
//   A request on req carries req_type (0 encrypt, 1 decrypt) and operand_value.
//   Each request yields one response on rsp: result_value and error.
//   A modulus below 2 returns 0 with error set; the sequencer goes straight to the
//   finish state, which loads the response into the output register once it is free.
//   Otherwise the operand is first reduced (one pass through the cell row), then
//   32 exponent bits are processed from the top, each a square plus a multiply
//   when the bit is set. Every pass goes through the single CHAIN_W-cell
//   multiplier row. One request is processed at a time.
//   The next request is taken while a finished response waits in the output
//   register; if the receiver still stalls when the next result is ready, the
//   sequencer holds it until the output register frees.
//   Reset clears the configuration registers to zero and empties the block.
module rsa_encrypt_decrypt_core
    import rsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    rsa_req_if.sink              req,
    rsa_rsp_if.source            rsp
);

    logic [DATA_W-1:0]  modulus_reg;
    logic [EXP_W-1:0]   pub_exp_reg;
    logic [EXP_W-1:0]   priv_exp_reg;
    logic [MOD_W-1:0]   m_w;

    seq_state_t         state_reg, state_next;
    logic [MOD_W-1:0]   a_reg, a_next;
    logic [CHAIN_W-1:0] b_reg, b_next;
    logic               launch_reg, launch_next;
    logic [MOD_W-1:0]   base_reg, base_next;
    logic [MOD_W-1:0]   acc_reg, acc_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]  res_reg, res_next;
    logic               err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;
    logic               out_err_reg, out_err_next;

    link_t              done;
    logic               adv;
    logic [MOD_W-1:0]   adv_acc;

    assign m_w = MOD_W'(modulus_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= '0;
            pub_exp_reg  <= '0;
            priv_exp_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS:     modulus_reg  <= cfg_wdata;
                REG_PUBLIC_EXP:  pub_exp_reg  <= cfg_wdata;
                REG_PRIVATE_EXP: priv_exp_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    rsa_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch_reg),
        .a      (a_reg),
        .b      (b_reg),
        .m      (m_w),
        .done   (done)
    );

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        launch_next    = 1'b0;
        base_next      = base_reg;
        acc_next       = acc_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        adv            = 1'b0;
        adv_acc        = done.acc;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (m_w < MOD_W'(2))
                    begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        a_next      = MOD_W'(1);
                        b_next      = CHAIN_W'(req.operand_value);
                        launch_next = 1'b1;
                        exp_next    = req.req_type ? priv_exp_reg : pub_exp_reg;
                        err_next    = 1'b0;
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (done.valid)
                begin
                    base_next   = done.acc;
                    acc_next    = MOD_W'(1);
                    cnt_next    = CNT_W'(EXP_W);
                    a_next      = MOD_W'(1);
                    b_next      = CHAIN_W'(1);
                    launch_next = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (done.valid)
                begin
                    acc_next = done.acc;
                    if (exp_reg[EXP_W-1])
                    begin
                        a_next      = done.acc;
                        b_next      = CHAIN_W'(base_reg);
                        launch_next = 1'b1;
                        state_next  = ST_MULT;
                    end
                    else
                        adv = 1'b1;
                end
            end
            ST_MULT:
            begin
                if (done.valid)
                begin
                    acc_next = done.acc;
                    adv      = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // advance to the next exponent bit, or finish after the last one
        if (adv)
        begin
            exp_next = exp_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                res_next   = DATA_W'(adv_acc);
                state_next = ST_FINISH;
            end
            else
            begin
                a_next      = adv_acc;
                b_next      = CHAIN_W'(adv_acc);
                launch_next = 1'b1;
                state_next  = ST_SQUARE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        exp_reg       <= exp_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        err_reg       <= err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.error        = out_err_reg;

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> (state_reg == ST_REDUCE || state_reg == ST_SQUARE
                        || state_reg == ST_MULT))
        else $error("product finished outside a wait state");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_value_reg == '0)
        else $error("error response with nonzero result");

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MULT |-> acc_reg < m_w && base_reg < m_w)
        else $error("operand not reduced below modulus");

    a_launch_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> $past(state_next) != ST_IDLE && $past(state_next) != ST_FINISH)
        else $error("launch without a pending product");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the RSA exponentiation core: directed table, then random keys.
module testbench;
    import rsa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] result_value;
        logic        error;
    } rsa_result_t;

    typedef struct {
        logic        new_keys;
        logic [31:0] n;
        logic [31:0] e;
        logic [31:0] d;
        logic        req_type;
        logic [31:0] operand;
        logic        known;
        logic [31:0] result_value;
        logic        error;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_wdata;

    rsa_req_if req ();
    rsa_rsp_if rsp ();

    rsa_encrypt_decrypt_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    logic [31:0] key_n;
    logic [31:0] key_e;
    logic [31:0] key_d;
    rsa_result_t pending_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int error_results = 0;
    int requests_sent;
    int key_sets;
    int stall_left = 0;
    bit no_idle;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] modexp(input logic [31:0] b, input logic [31:0] e,
                                           input logic [31:0] m);
        logic [63:0] acc;
        logic [63:0] base;
        acc  = 64'd1 % m;
        base = b % m;
        for (int i = 31; i >= 0; i--)
        begin
            acc = (acc * acc) % m;
            if (e[i])
                acc = (acc * base) % m;
        end
        return acc[31:0];
    endfunction

    function automatic rsa_result_t rsa_predict(input logic rt, input logic [31:0] op);
        rsa_result_t r;
        if (key_n < 2)
        begin
            r.result_value = '0;
            r.error        = 1'b1;
        end
        else
        begin
            r.result_value = modexp(op, rt ? key_d : key_e, key_n);
            r.error        = 1'b0;
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // hold ready low at random, check each result against the oldest prediction
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (rsp.error)
                error_results++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h error %b", rsp.result_value, rsp.error);
            end
            else
            begin
                rsa_result_t x;
                x = pending_results.pop_front();
                if (rsp.result_value !== x.result_value || rsp.error !== x.error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h/%b got %h/%b",
                                 x.result_value, x.error, rsp.result_value, rsp.error);
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp.ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 9) < 3)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 3);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic load_keys(input logic [31:0] n, input logic [31:0] e, input logic [31:0] d);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODULUS;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_index <= REG_PUBLIC_EXP;
        cfg_wdata <= e;
        @(posedge clk);
        cfg_index <= REG_PRIVATE_EXP;
        cfg_wdata <= d;
        @(posedge clk);
        // index past the register list: dropped by the block
        cfg_index <= REG_UNUSED;
        cfg_wdata <= $urandom();
        @(posedge clk);
        cfg_we <= 1'b0;
        key_n = n;
        key_e = e;
        key_d = d;
        key_sets++;
    endtask

    task automatic issue(input logic rt, input logic [31:0] op, input logic known,
                         input rsa_result_t typed);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.req_type      <= rt;
        req.operand_value <= op;
        do
            @(posedge clk);
        while (!req.ready);
        pending_results.push_back(known ? typed : rsa_predict(rt, op));
        requests_sent++;
    endtask

    dir_row_t dir_rows[] = '{
        '{1'b0, 0, 0, 0, 1'b0, 32'd65, 1'b1, 32'd0, 1'b1},
        '{1'b0, 0, 0, 0, 1'b1, 32'hFFFFFFFF, 1'b1, 32'd0, 1'b1},
        '{1'b1, 32'd3233, 32'd17, 32'd2753, 1'b0, 32'd65, 1'b1, 32'd2790, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'd2790, 1'b1, 32'd65, 1'b0},
        '{1'b0, 0, 0, 0, 1'b0, 32'd0, 1'b1, 32'd0, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'd3233, 1'b1, 32'd0, 1'b0},
        '{1'b0, 0, 0, 0, 1'b0, 32'd3298, 1'b1, 32'd2790, 1'b0},
        '{1'b0, 0, 0, 0, 1'b0, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'h80000000, 1'b0, 32'd0, 1'b0},
        '{1'b1, 32'd1, 32'd17, 32'd5, 1'b0, 32'd7, 1'b1, 32'd0, 1'b1},
        '{1'b0, 0, 0, 0, 1'b1, 32'd0, 1'b1, 32'd0, 1'b1},
        '{1'b1, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 1'b0, 32'h12345678, 1'b1, 32'd1, 1'b0},
        '{1'b0, 0, 0, 0, 1'b0, 32'hFFFFFFFF, 1'b1, 32'd1, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'd0, 1'b1, 32'd0, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'd1, 1'b1, 32'd1, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'hFFFFFFFE, 1'b0, 32'd0, 1'b0},
        '{1'b1, 32'd2, 32'hFFFFFFFF, 32'd1, 1'b0, 32'd3, 1'b1, 32'd1, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'd2, 1'b1, 32'd0, 1'b0},
        '{1'b0, 0, 0, 0, 1'b0, 32'hFFFFFFFF, 1'b1, 32'd1, 1'b0},
        '{1'b1, 32'hFFFFFFFB, 32'h55555555, 32'hAAAAAAAA, 1'b0, 32'hDEADBEEF, 1'b0, 0, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'hFFFFFFFB, 1'b0, 0, 1'b0},
        '{1'b0, 0, 0, 0, 1'b1, 32'hFFFFFFFC, 1'b0, 0, 1'b0}
    };

    initial
    begin
        rsa_result_t typed;
        logic [31:0] n;
        logic [31:0] e;
        logic [31:0] d;
        logic [31:0] op;
        int pick;
        requests_sent     = 0;
        key_sets          = 0;
        no_idle           = 1'b0;
        key_n             = '0;
        key_e             = '0;
        key_d             = '0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_MODULUS;
        cfg_wdata         = '0;
        req.valid         = 1'b0;
        req.req_type      = 1'b0;
        req.operand_value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].new_keys)
                load_keys(dir_rows[i].n, dir_rows[i].e, dir_rows[i].d);
            typed.result_value = dir_rows[i].result_value;
            typed.error        = dir_rows[i].error;
            issue(dir_rows[i].req_type, dir_rows[i].operand, dir_rows[i].known, typed);
        end

        for (int k = 0; k < 12; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                n = $urandom_range(2, 5000);
            else if (pick < 8)
                n = $urandom();
            else if (pick == 8)
                n = 32'hFFFFFFFF;
            else
                n = $urandom_range(0, 1);
            e = $urandom();
            d = $urandom();
            if ($urandom_range(0, 5) == 0)
                e = ($urandom_range(0, 1) == 1) ? 32'hFFFFFFFF : 32'd0;
            if ($urandom_range(0, 5) == 0)
                d = ($urandom_range(0, 1) == 1) ? 32'hFFFFFFFF : 32'd0;
            load_keys(n, e, d);
            no_idle = (k % 4 == 3);
            for (int j = 0; j < 73; j++)
            begin
                op = $urandom();
                if (n >= 2 && $urandom_range(0, 2) != 0)
                    op = op % n;
                issue(1'($urandom_range(0, 1)), op, 1'b0, typed);
            end
        end

        no_idle = 1'b0;
        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d requests over %0d key sets, %0d results (%0d flagged error)",
                 requests_sent, key_sets, results_seen, error_results);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("testbench: errors");
        $finish;
    end

endmodule
